FILE: design/dcbs_pkg.sv
// Shared types and constants for the display command block sequencer.
// Used by dcbs_ring, dcbs_engine and display_command_block_sequencer.
package dcbs_pkg;

  // Default number of descriptor slots in the ring.
  localparam int RING_DEPTH_DEF = 32;

  // Item opcodes.
  localparam logic OP_ENQ  = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // Block kinds. Kind three behaves as a fixed block.
  localparam logic [1:0] KIND_STD    = 2'd0;
  localparam logic [1:0] KIND_FIXED  = 2'd1;
  localparam logic [1:0] KIND_REPEAT = 2'd2;

  // Sending phase of the active block.
  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_CMD  = 2'd1,
    PH_DATA = 2'd2
  } phase_t;

  // One block descriptor as stored in the ring.
  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] clen;
    logic [15:0] dlen;
    logic [15:0] base;
  } desc_t;

  // Ring update requests from the engine.
  typedef struct packed {
    logic push;
    logic pop;
  } ring_ctl_t;

  // Ring status seen by the engine.
  typedef struct packed {
    logic  empty;
    logic  full;
    desc_t head;
  } ring_sts_t;

  // Per-beat result of the engine, before the ring fill fields are added.
  typedef struct packed {
    logic        enq_refused;
    logic        byte_valid;
    logic [15:0] byte_addr;
    logic        byte_is_data;
    logic        block_done;
    logic        release_valid;
    logic [15:0] release_addr;
    logic        busy;
  } res_t;

endpackage

FILE: design/dcbs_ring.sv
// Descriptor ring: storage memory, head and tail pointers, fill count and a
// registered head read with write bypass. Depends on dcbs_pkg.
module dcbs_ring #(
  parameter int RING_DEPTH = dcbs_pkg::RING_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  dcbs_pkg::ring_ctl_t              ctl,
  input  dcbs_pkg::desc_t                  wr_desc,
  output dcbs_pkg::ring_sts_t              sts,
  output logic [$clog2(RING_DEPTH+1)-1:0]  cnt_nxt,
  output logic                             full_nxt
);

  localparam int IW = $clog2(RING_DEPTH);
  localparam int CW = $clog2(RING_DEPTH + 1);
  localparam logic [IW-1:0] LAST_IDX = IW'(RING_DEPTH - 1);
  localparam logic [CW-1:0] DEPTH_C  = CW'(RING_DEPTH);

  dcbs_pkg::desc_t mem [RING_DEPTH];

  logic [IW-1:0]   head_r, head_nxt;
  logic [IW-1:0]   tail_r, tail_nxt;
  logic [CW-1:0]   cnt_r;
  logic [IW-1:0]   rd_addr;
  dcbs_pkg::desc_t rd_q_r;
  dcbs_pkg::desc_t byp_data_r;
  logic            byp_r, byp_nxt;

  // Pointer advance with wrap at the last slot.
  assign head_nxt = (head_r == LAST_IDX) ? '0 : head_r + 1'b1;
  assign tail_nxt = (tail_r == LAST_IDX) ? '0 : tail_r + 1'b1;

  // The read port always looks at the slot that will be the head next cycle.
  assign rd_addr = ctl.pop ? head_nxt : head_r;
  assign byp_nxt = ctl.push && (tail_r == rd_addr);

  // Fill count after this cycle's update.
  always_comb begin
    cnt_nxt = cnt_r;
    if (ctl.push) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (ctl.pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end
  assign full_nxt = (cnt_nxt == DEPTH_C);

  // Memory write and registered read.
  always_ff @(posedge clk) begin
    if (ctl.push) begin
      mem[tail_r] <= wr_desc;
    end
    rd_q_r     <= mem[rd_addr];
    byp_data_r <= wr_desc;
  end

  // Pointers, count and bypass flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      cnt_r  <= '0;
      byp_r  <= 1'b0;
    end else begin
      if (ctl.pop) begin
        head_r <= head_nxt;
      end
      if (ctl.push) begin
        tail_r <= tail_nxt;
      end
      cnt_r <= cnt_nxt;
      byp_r <= byp_nxt;
    end
  end

  // A slot written in the same cycle it is read comes from the bypass.
  assign sts.empty = (cnt_r == '0);
  assign sts.full  = (cnt_r == DEPTH_C);
  assign sts.head  = byp_r ? byp_data_r : rd_q_r;

  // The count never goes beyond the number of slots.
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= DEPTH_C)
    else $error("ring count exceeds depth");

  // No push into a full ring, no pop from an empty one.
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    !(ctl.push && sts.full) && !(ctl.pop && sts.empty))
    else $error("ring overrun or underrun");

  // Head and tail meet only when the ring is empty or full.
  a_ptr_meet: assert property (@(posedge clk) disable iff (!rst_n)
    (head_r == tail_r) |-> (cnt_r == '0 || cnt_r == DEPTH_C))
    else $error("ring pointers disagree with count");

  // Push and pop never happen in the same cycle.
  a_one_op: assert property (@(posedge clk) disable iff (!rst_n)
    !(ctl.push && ctl.pop))
    else $error("ring push and pop together");

endmodule

FILE: design/dcbs_engine.sv
// Sending engine: phase state machine, active block counters and the
// per-beat result logic. Depends on dcbs_pkg.
module dcbs_engine (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                adv,
  input  logic                op,
  input  logic [1:0]          blk_kind,
  input  logic [15:0]         base_addr,
  input  dcbs_pkg::ring_sts_t sts,
  output dcbs_pkg::ring_ctl_t ctl,
  output dcbs_pkg::res_t      res
);

  dcbs_pkg::phase_t ph_r, ph_nxt;
  logic [1:0]       kind_r, kind_nxt;
  logic [15:0]      cl_r, cl_nxt;
  logic [15:0]      dl_r, dl_nxt;
  logic [15:0]      addr_r, addr_nxt;
  logic [15:0]      base_r, base_nxt;
  logic             send;
  logic             finish;

  // Phase register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r <= dcbs_pkg::PH_IDLE;
    end else if (adv) begin
      ph_r <= ph_nxt;
    end
  end

  // Active block registers; only meaningful while a block is being sent.
  always_ff @(posedge clk) begin
    if (adv) begin
      kind_r <= kind_nxt;
      cl_r   <= cl_nxt;
      dl_r   <= dl_nxt;
      addr_r <= addr_nxt;
      base_r <= base_nxt;
    end
  end

  // Next state and result for the beat in the input register.
  always_comb begin
    res      = '0;
    ctl      = '0;
    ph_nxt   = ph_r;
    kind_nxt = kind_r;
    cl_nxt   = cl_r;
    dl_nxt   = dl_r;
    addr_nxt = addr_r;
    base_nxt = base_r;
    send     = 1'b0;
    finish   = 1'b0;

    if (op == dcbs_pkg::OP_ENQ) begin
      // Enqueue: store the descriptor or refuse it when the ring is full.
      if (sts.full) begin
        res.enq_refused = 1'b1;
        if (blk_kind == dcbs_pkg::KIND_STD) begin
          res.release_valid = 1'b1;
          res.release_addr  = base_addr;
        end
      end else begin
        ctl.push = adv;
      end
    end else begin
      // Tick: pop a new block when idle, otherwise continue the active one.
      unique case (ph_r) inside
        dcbs_pkg::PH_IDLE: begin
          if (!sts.empty) begin
            ctl.pop  = adv;
            kind_nxt = sts.head.kind;
            cl_nxt   = sts.head.clen;
            dl_nxt   = sts.head.dlen;
            addr_nxt = sts.head.base;
            base_nxt = sts.head.base;
            if (sts.head.clen != '0) begin
              ph_nxt = dcbs_pkg::PH_CMD;
              send   = 1'b1;
            end else if (sts.head.dlen != '0) begin
              ph_nxt = dcbs_pkg::PH_DATA;
              send   = 1'b1;
            end else begin
              finish = 1'b1;
            end
          end
        end
        dcbs_pkg::PH_CMD, dcbs_pkg::PH_DATA: begin
          send = 1'b1;
        end
        default: begin
          ph_nxt = dcbs_pkg::PH_IDLE;
        end
      endcase

      // Emit one byte address and step the counters.
      if (send) begin
        res.byte_valid = 1'b1;
        res.byte_addr  = addr_nxt;
        if (ph_nxt == dcbs_pkg::PH_CMD) begin
          addr_nxt = addr_nxt + 16'd1;
          if (cl_nxt == 16'd1) begin
            if (dl_nxt == '0) begin
              finish = 1'b1;
            end else begin
              ph_nxt = dcbs_pkg::PH_DATA;
            end
          end
          cl_nxt = cl_nxt - 16'd1;
        end else begin
          res.byte_is_data = 1'b1;
          if (kind_nxt != dcbs_pkg::KIND_REPEAT) begin
            addr_nxt = addr_nxt + 16'd1;
          end
          if (dl_nxt == 16'd1) begin
            finish = 1'b1;
          end
          dl_nxt = dl_nxt - 16'd1;
        end
      end

      // End of block: a standard buffer goes back for freeing.
      if (finish) begin
        res.block_done = 1'b1;
        if (kind_nxt == dcbs_pkg::KIND_STD) begin
          res.release_valid = 1'b1;
          res.release_addr  = base_nxt;
        end
        ph_nxt = dcbs_pkg::PH_IDLE;
      end
    end

    res.busy = (ph_nxt != dcbs_pkg::PH_IDLE);
  end

endmodule

FILE: design/display_command_block_sequencer.sv
// Top level of the display command block sequencer: input register, result
// register and the handshakes. Depends on dcbs_pkg, dcbs_ring, dcbs_engine.
//
// Use: the input channel carries two kinds of beats. An enqueue beat
// (in_op = 0) appends a block descriptor to the ring, or is refused when the
// ring is full. A tick beat (in_op = 1) stands for one byte slot on the
// display link: it pops the next descriptor when no block is active and
// returns at most one byte address with its D/C level. Every input beat
// produces exactly one result beat, which also reports the ring fill and
// busy state. Throughput: one beat per cycle while out_stall stays low;
// each beat passes once through the input register, the engine logic and
// the result register, and its result is offered on the out_ ports.
// Reset: the ring is empty, no block is active and both registers are empty.
// Ring slots hold no reset value; only written slots are ever popped.
// When the receiver raises out_stall the result register holds its beat,
// the input register fills behind it, and in_stall then rises.
module display_command_block_sequencer #(
  parameter int RING_DEPTH = dcbs_pkg::RING_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_op,
  input  logic [1:0]  in_blk_kind,
  input  logic [15:0] in_cmd_len,
  input  logic [15:0] in_data_len,
  input  logic [15:0] in_base_addr,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_enq_refused,
  output logic        out_byte_valid,
  output logic [15:0] out_byte_addr,
  output logic        out_byte_is_data,
  output logic        out_block_done,
  output logic        out_release_valid,
  output logic [15:0] out_release_addr,
  output logic        out_ring_full,
  output logic [5:0]  out_ring_count,
  output logic        out_busy_res
);

  localparam int CW = $clog2(RING_DEPTH + 1);

  logic                in_vld_r, in_vld_nxt;
  logic                op_r;
  logic [1:0]          kind_r;
  logic [15:0]         clen_r;
  logic [15:0]         dlen_r;
  logic [15:0]         base_r;
  logic                out_vld_r, out_vld_nxt;
  dcbs_pkg::res_t      res;
  dcbs_pkg::res_t      res_r;
  logic                full_r;
  logic [5:0]          count_r;
  logic                in_acc;
  logic                out_acc;
  logic                adv;
  dcbs_pkg::ring_ctl_t ring_ctl;
  dcbs_pkg::ring_sts_t ring_sts;
  dcbs_pkg::desc_t     wr_desc;
  logic [CW-1:0]       cnt_nxt;
  logic                full_nxt;

  // Handshake: the beat in the input register moves on when the result
  // register is empty or being drained.
  assign adv      = in_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = in_vld_r && !adv;
  assign in_acc   = in_valid && !in_stall;
  assign out_acc  = out_vld_r && !out_stall;

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (in_acc) begin
      in_vld_nxt = 1'b1;
    end else if (adv) begin
      in_vld_nxt = 1'b0;
    end
    out_vld_nxt = out_vld_r;
    if (adv) begin
      out_vld_nxt = 1'b1;
    end else if (out_acc) begin
      out_vld_nxt = 1'b0;
    end
  end

  // Valid flags of both registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // Input register payload.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r   <= in_op;
      kind_r <= in_blk_kind;
      clen_r <= in_cmd_len;
      dlen_r <= in_data_len;
      base_r <= in_base_addr;
    end
  end

  assign wr_desc.kind = kind_r;
  assign wr_desc.clen = clen_r;
  assign wr_desc.dlen = dlen_r;
  assign wr_desc.base = base_r;

  // Descriptor ring.
  dcbs_ring #(
    .RING_DEPTH (RING_DEPTH)
  ) u_ring (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (ring_ctl),
    .wr_desc  (wr_desc),
    .sts      (ring_sts),
    .cnt_nxt  (cnt_nxt),
    .full_nxt (full_nxt)
  );

  // Sending engine.
  dcbs_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .op        (op_r),
    .blk_kind  (kind_r),
    .base_addr (base_r),
    .sts       (ring_sts),
    .ctl       (ring_ctl),
    .res       (res)
  );

  // Result register payload.
  always_ff @(posedge clk) begin
    if (adv) begin
      res_r   <= res;
      full_r  <= full_nxt;
      count_r <= 6'(cnt_nxt);
    end
  end

  assign out_valid         = out_vld_r;
  assign out_enq_refused   = res_r.enq_refused;
  assign out_byte_valid    = res_r.byte_valid;
  assign out_byte_addr     = res_r.byte_addr;
  assign out_byte_is_data  = res_r.byte_is_data;
  assign out_block_done    = res_r.block_done;
  assign out_release_valid = res_r.release_valid;
  assign out_release_addr  = res_r.release_addr;
  assign out_ring_full     = full_r;
  assign out_ring_count    = count_r;
  assign out_busy_res      = res_r.busy;

endmodule

FILE: test/tb_display_command_block_sequencer.sv
// Self-checking testbench for the display command block sequencer.
// Depends on dcbs_pkg and display_command_block_sequencer; holds its own
// scoreboard that predicts every result beat from the accepted input beats.
`timescale 1ns / 1ps

localparam int SEQ_DEPTH = dcbs_pkg::RING_DEPTH_DEF;

// One result beat as seen on the out_ ports.
typedef struct packed {
  logic        enq_refused;
  logic        byte_valid;
  logic [15:0] byte_addr;
  logic        byte_is_data;
  logic        block_done;
  logic        release_valid;
  logic [15:0] release_addr;
  logic        ring_full;
  logic [5:0]  ring_count;
  logic        busy;
} seq_beat_t;

// Scoreboard: mirrors the ring and the send engine, and queues the result
// beat that each accepted input beat must produce.
class dcbs_scoreboard;
  dcbs_pkg::desc_t  slots[SEQ_DEPTH];
  int               head;
  int               tail;
  int               fill;
  dcbs_pkg::phase_t phase;
  logic [1:0]       act_kind;
  logic [15:0]      cmd_left;
  logic [15:0]      data_left;
  logic [15:0]      cur_addr;
  logic [15:0]      act_base;
  seq_beat_t        expected_beats[$];
  int               errors;

  function new();
    head = 0;
    tail = 0;
    fill = 0;
    phase = dcbs_pkg::PH_IDLE;
    act_kind = '0;
    cmd_left = '0;
    data_left = '0;
    cur_addr = '0;
    act_base = '0;
    errors = 0;
  endfunction

  function int pending();
    return expected_beats.size();
  endfunction

  function bit idle_empty();
    return phase == dcbs_pkg::PH_IDLE && fill == 0;
  endfunction

  // End of the active block: a standard buffer goes back for freeing.
  function void close_block(inout seq_beat_t r);
    r.block_done = 1'b1;
    if (act_kind == dcbs_pkg::KIND_STD) begin
      r.release_valid = 1'b1;
      r.release_addr = act_base;
    end
    phase = dcbs_pkg::PH_IDLE;
  endfunction

  // One byte of the active block; repeat blocks keep the data address.
  function void emit_byte(inout seq_beat_t r);
    r.byte_valid = 1'b1;
    r.byte_addr = cur_addr;
    if (phase == dcbs_pkg::PH_CMD) begin
      r.byte_is_data = 1'b0;
      cur_addr = cur_addr + 16'd1;
      cmd_left = cmd_left - 16'd1;
      if (cmd_left == 16'd0) begin
        if (data_left == 16'd0) close_block(r);
        else phase = dcbs_pkg::PH_DATA;
      end
    end else begin
      r.byte_is_data = 1'b1;
      if (act_kind != dcbs_pkg::KIND_REPEAT) cur_addr = cur_addr + 16'd1;
      data_left = data_left - 16'd1;
      if (data_left == 16'd0) close_block(r);
    end
  endfunction

  // Called once per accepted input beat.
  function void predict_beat(bit op, bit [1:0] kind, bit [15:0] clen, bit [15:0] dlen,
                             bit [15:0] base);
    seq_beat_t r;
    r = '0;
    if (op == dcbs_pkg::OP_ENQ) begin
      if (fill >= SEQ_DEPTH) begin
        r.enq_refused = 1'b1;
        if (kind == dcbs_pkg::KIND_STD) begin
          r.release_valid = 1'b1;
          r.release_addr = base;
        end
      end else begin
        slots[tail].kind = kind;
        slots[tail].clen = clen;
        slots[tail].dlen = dlen;
        slots[tail].base = base;
        tail = (tail + 1 >= SEQ_DEPTH) ? 0 : tail + 1;
        fill++;
      end
    end else if (phase == dcbs_pkg::PH_IDLE) begin
      // Pop and send the first byte in the same slot.
      if (fill > 0) begin
        act_kind = slots[head].kind;
        cmd_left = slots[head].clen;
        data_left = slots[head].dlen;
        cur_addr = slots[head].base;
        act_base = slots[head].base;
        head = (head + 1 >= SEQ_DEPTH) ? 0 : head + 1;
        fill--;
        if (cmd_left != 16'd0) begin
          phase = dcbs_pkg::PH_CMD;
          emit_byte(r);
        end else if (data_left != 16'd0) begin
          phase = dcbs_pkg::PH_DATA;
          emit_byte(r);
        end else begin
          close_block(r);
        end
      end
    end else begin
      emit_byte(r);
    end
    r.ring_full = (fill >= SEQ_DEPTH);
    r.ring_count = fill[5:0];
    r.busy = (phase != dcbs_pkg::PH_IDLE);
    expected_beats.push_back(r);
  endfunction

  task report_mismatch(string what);
    errors++;
    $display("mismatch %0d: %s", errors, what);
  endtask

  task check_field(string name, logic [15:0] got, logic [15:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %h want %h", name, got, want));
  endtask

  // Called once per accepted result beat.
  task check_beat(seq_beat_t got);
    seq_beat_t want;
    if (expected_beats.size() == 0) begin
      report_mismatch("result beat with no input beat waiting");
    end else begin
      want = expected_beats.pop_front();
      check_field("enq_refused", 16'(got.enq_refused), 16'(want.enq_refused));
      check_field("byte_valid", 16'(got.byte_valid), 16'(want.byte_valid));
      check_field("byte_addr", got.byte_addr, want.byte_addr);
      check_field("byte_is_data", 16'(got.byte_is_data), 16'(want.byte_is_data));
      check_field("block_done", 16'(got.block_done), 16'(want.block_done));
      check_field("release_valid", 16'(got.release_valid), 16'(want.release_valid));
      check_field("release_addr", got.release_addr, want.release_addr);
      check_field("ring_full", 16'(got.ring_full), 16'(want.ring_full));
      check_field("ring_count", 16'(got.ring_count), 16'(want.ring_count));
      check_field("busy_res", 16'(got.busy), 16'(want.busy));
    end
  endtask
endclass

module tb_display_command_block_sequencer;

  localparam int CYCLE_LIMIT = 400000;
  localparam int ITEM_TARGET = 740;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_op = 1'b0;
  logic [1:0]  in_blk_kind = '0;
  logic [15:0] in_cmd_len = '0;
  logic [15:0] in_data_len = '0;
  logic [15:0] in_base_addr = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_enq_refused;
  logic        out_byte_valid;
  logic [15:0] out_byte_addr;
  logic        out_byte_is_data;
  logic        out_block_done;
  logic        out_release_valid;
  logic [15:0] out_release_addr;
  logic        out_ring_full;
  logic [5:0]  out_ring_count;
  logic        out_busy_res;

  dcbs_scoreboard sb = new();
  seq_beat_t      seen_beat;
  int             burst_left = 0;
  int             items_sent = 0;
  int             cycles = 0;
  int             stall_mode = 0;
  int             stall_win = 0;

  display_command_block_sequencer #(
    .RING_DEPTH(SEQ_DEPTH)
  ) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_op(in_op),
    .in_blk_kind(in_blk_kind),
    .in_cmd_len(in_cmd_len),
    .in_data_len(in_data_len),
    .in_base_addr(in_base_addr),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_enq_refused(out_enq_refused),
    .out_byte_valid(out_byte_valid),
    .out_byte_addr(out_byte_addr),
    .out_byte_is_data(out_byte_is_data),
    .out_block_done(out_block_done),
    .out_release_valid(out_release_valid),
    .out_release_addr(out_release_addr),
    .out_ring_full(out_ring_full),
    .out_ring_count(out_ring_count),
    .out_busy_res(out_busy_res)
  );

  // 4 ns clock.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Run limit.
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Receiver stall: windows of random length, each with its own stall density.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (stall_win == 0) begin
        stall_mode = $urandom_range(0, 3);
        stall_win = $urandom_range(8, 64);
      end else begin
        stall_win--;
      end
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        2: out_stall <= ($urandom_range(0, 1) == 0);
        default: out_stall <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  // Result monitor: every accepted result beat is checked.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      seen_beat.enq_refused = out_enq_refused;
      seen_beat.byte_valid = out_byte_valid;
      seen_beat.byte_addr = out_byte_addr;
      seen_beat.byte_is_data = out_byte_is_data;
      seen_beat.block_done = out_block_done;
      seen_beat.release_valid = out_release_valid;
      seen_beat.release_addr = out_release_addr;
      seen_beat.ring_full = out_ring_full;
      seen_beat.ring_count = out_ring_count;
      seen_beat.busy = out_busy_res;
      sb.check_beat(seen_beat);
    end
  end

  // Drive one input beat, with a random gap between bursts, and wait for it
  // to be accepted.
  task automatic push_beat(input bit op, input bit [1:0] kind, input bit [15:0] clen,
                           input bit [15:0] dlen, input bit [15:0] base);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 12) : $urandom_range(0, 3);
      burst_left = $urandom_range(1, 40);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    items_sent++;
    in_valid <= 1'b1;
    in_op <= op;
    in_blk_kind <= kind;
    in_cmd_len <= clen;
    in_data_len <= dlen;
    in_base_addr <= base;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.predict_beat(op, kind, clen, dlen, base);
  endtask

  task automatic enqueue(input bit [1:0] kind, input bit [15:0] clen, input bit [15:0] dlen,
                         input bit [15:0] base);
    push_beat(dcbs_pkg::OP_ENQ, kind, clen, dlen, base);
  endtask

  // A tick carries random values in the fields it ignores.
  task automatic tick();
    push_beat(dcbs_pkg::OP_TICK, 2'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
  endtask

  // Tick until the ring is empty and no block is active.
  task automatic drain_ring();
    while (!sb.idle_empty()) tick();
  endtask

  // Sender holds off until every expected result beat has arrived.
  task automatic pause_until_quiet();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    burst_left = 0;
  endtask

  function automatic bit [15:0] short_len();
    case ($urandom_range(0, 9))
      0: return 16'd0;
      1, 2, 3, 4, 5, 6: return 16'($urandom_range(0, 3));
      default: return 16'($urandom_range(4, 12));
    endcase
  endfunction

  // Bases near the top of the address space exercise the wrap.
  function automatic bit [15:0] rand_base();
    if ($urandom_range(0, 4) == 0) return 16'($urandom_range(16'hFFF0, 16'hFFFF));
    return 16'($urandom_range(0, 16'hFFFF));
  endfunction

  task automatic enqueue_short();
    enqueue(2'($urandom_range(0, 3)), short_len(), short_len(), rand_base());
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty tick, address wrap, repeat block, zero-length blocks,
    // kind three, enqueue while busy.
    tick();
    enqueue(dcbs_pkg::KIND_STD, 16'd2, 16'd1, 16'hFFFF);
    enqueue(dcbs_pkg::KIND_REPEAT, 16'd1, 16'd2, 16'h1234);
    repeat (3) tick();
    enqueue(dcbs_pkg::KIND_FIXED, 16'd0, 16'd0, 16'h00A0);
    enqueue(dcbs_pkg::KIND_STD, 16'd0, 16'd0, 16'hBEEF);
    repeat (5) tick();
    enqueue(2'd3, 16'd0, 16'd2, 16'hFFFF);
    tick();
    enqueue(dcbs_pkg::KIND_STD, 16'd1, 16'd0, 16'h0000);
    repeat (3) tick();
    enqueue(dcbs_pkg::KIND_REPEAT, 16'd0, 16'd1, 16'h5555);
    tick();

    // Random phases of traffic.
    while (items_sent < ITEM_TARGET) begin
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11: begin
          // Mixed traffic, mostly ticks.
          repeat (30) begin
            if ($urandom_range(0, 4) == 0) enqueue_short();
            else tick();
          end
        end
        12, 13, 14: begin
          // Fill past the top so that enqueues are refused, then drain.
          repeat (SEQ_DEPTH + $urandom_range(1, 4))
            enqueue(2'($urandom_range(0, 3)), 16'($urandom_range(0, 2)),
                    16'($urandom_range(0, 2)), rand_base());
          drain_ring();
        end
        15, 16: begin
          // Quiet the block, then tick on an empty ring.
          drain_ring();
          pause_until_quiet();
          repeat ($urandom_range(1, 3)) tick();
        end
        default: begin
          // Noise: any kind, random op mix.
          repeat (20) begin
            if ($urandom_range(0, 1) == 0)
              enqueue(2'($urandom_range(0, 3)), 16'($urandom_range(0, 8)),
                      16'($urandom_range(0, 8)), 16'($urandom_range(0, 16'hFFFF)));
            else
              tick();
          end
        end
      endcase
    end

    // Full-range lengths last, since such blocks are never sent to the end.
    drain_ring();
    enqueue(2'($urandom_range(0, 3)), 16'($urandom_range(0, 16'hFFFF)),
            16'($urandom_range(0, 16'hFFFF)), 16'($urandom_range(0, 16'hFFFF)));
    repeat (120) tick();
    enqueue(dcbs_pkg::KIND_STD, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    repeat (SEQ_DEPTH + 3)
      enqueue(2'($urandom_range(0, 3)), 16'($urandom_range(0, 16'hFFFF)),
              16'($urandom_range(0, 16'hFFFF)), 16'($urandom_range(0, 16'hFFFF)));
    repeat (10) tick();

    // Wait for the last result beats, then a few cycles for stray beats.
    pause_until_quiet();
    repeat (8) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
